/* src/cpu8_pkg.sv */
package cpu8_pkg;

    localparam int unsigned QueueDepth = 2;

    typedef enum logic [5:0] {
        OP_LDA = 6'd0,  OP_LDX = 6'd1,  OP_LDY = 6'd2,  OP_STA = 6'd3,
        OP_STX = 6'd4,  OP_STY = 6'd5,  OP_ADC = 6'd6,  OP_SBC = 6'd7,
        OP_AND = 6'd8,  OP_ORA = 6'd9,  OP_EOR = 6'd10, OP_CMP = 6'd11,
        OP_CPX = 6'd12, OP_CPY = 6'd13, OP_BIT = 6'd14,
        OP_ASLA = 6'd15, OP_LSRA = 6'd16, OP_ROLA = 6'd17, OP_RORA = 6'd18,
        OP_ASLM = 6'd19, OP_LSRM = 6'd20, OP_ROLM = 6'd21, OP_RORM = 6'd22,
        OP_INC = 6'd23, OP_DEC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26,
        OP_DEX = 6'd27, OP_DEY = 6'd28, OP_TAX = 6'd29, OP_TAY = 6'd30,
        OP_TSX = 6'd31, OP_TXA = 6'd32, OP_TXS = 6'd33, OP_TYA = 6'd34,
        OP_CLC = 6'd35, OP_SEC = 6'd36, OP_CLI = 6'd37, OP_SEI = 6'd38,
        OP_CLV = 6'd39, OP_CLD = 6'd40, OP_SED = 6'd41, OP_PHA = 6'd42,
        OP_PHP = 6'd43, OP_PLA = 6'd44, OP_PLP = 6'd45,
        OP_BCC = 6'd46, OP_BCS = 6'd47, OP_BEQ = 6'd48, OP_BNE = 6'd49,
        OP_BPL = 6'd50, OP_BMI = 6'd51, OP_BVC = 6'd52, OP_BVS = 6'd53,
        OP_NOP = 6'd54
    } op_t;

    // operation class, set by the front end
    typedef enum logic [2:0] {
        CL_NONE   = 3'd0,
        CL_ALU    = 3'd1,
        CL_STORE  = 3'd2,
        CL_PUSH   = 3'd3,
        CL_PULL   = 3'd4,
        CL_BRANCH = 3'd5
    } op_class_t;

    typedef struct packed {
        op_t       op;
        op_class_t cls;
        logic [7:0]  operand;
        logic [15:0] pc;
    } cpu8_word_t;

    localparam logic [7:0]  SpReset   = 8'hFD;
    localparam logic [7:0]  PlpMask   = 8'b11101111;
    localparam logic [7:0]  PhpMark   = 8'h30;
    localparam logic [8:0]  StackPage = 9'h100;
    localparam logic [15:0] PageMask  = 16'hFF00;

    function automatic op_class_t classify(input logic [5:0] op);
        op_class_t c;
        c = CL_ALU;
        if (op == OP_STA || op == OP_STX || op == OP_STY) c = CL_STORE;
        else if (op == OP_PHA || op == OP_PHP) c = CL_PUSH;
        else if (op == OP_PLA || op == OP_PLP) c = CL_PULL;
        else if (op >= OP_BCC && op <= OP_BVS) c = CL_BRANCH;
        else if (op >= OP_CLD) c = CL_NONE;
        return c;
    endfunction

endpackage

/* src/cpu8_front.sv */
module cpu8_front #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    output logic                stall_in,
    input  logic [5:0]          op,
    input  logic [7:0]          operand,
    input  logic [15:0]         pc_in,
    output logic                q_valid,
    input  logic                q_pop,
    output cpu8_pkg::cpu8_word_t q_word
);
    import cpu8_pkg::*;

    localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    cpu8_word_t     mem_reg [DEPTH];
    logic [IW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]  count_reg;
    logic           push, pop;
    cpu8_word_t     in_word;

    assign stall_in = (count_reg == CW'(DEPTH));
    assign push     = valid_in && !stall_in;
    assign pop      = q_pop && q_valid;
    assign q_valid  = (count_reg != '0);
    assign q_word   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        in_word.op      = op_t'(op);
        in_word.cls     = classify(op);
        in_word.operand = operand;
        in_word.pc      = pc_in;
    end

    function automatic logic [IW-1:0] bump(input logic [IW-1:0] p);
        return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (push) mem_reg[wr_ptr_reg] <= in_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push) wr_ptr_reg <= bump(wr_ptr_reg);
            if (pop) rd_ptr_reg <= bump(rd_ptr_reg);
            if (push && !pop) count_reg <= count_reg + 1'b1;
            else if (pop && !push) count_reg <= count_reg - 1'b1;
        end
    end
endmodule

/* src/cpu8_back.sv */
module cpu8_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  cpu8_pkg::cpu8_word_t q_word,
    output logic                 valid_out,
    input  logic                 stall_out,
    output logic [7:0]           result_byte,
    output logic                 mem_write,
    output logic [8:0]           stack_address,
    output logic [7:0]           acc_out,
    output logic [7:0]           x_out,
    output logic [7:0]           y_out,
    output logic [7:0]           status_out,
    output logic [7:0]           sp_out,
    output logic                 branch_taken,
    output logic [15:0]          branch_target,
    output logic                 page_crossed
);
    import cpu8_pkg::*;

    logic [7:0] a_reg, x_reg, y_reg, sp_reg;
    logic c_reg, z_reg, n_reg, v_reg, i_reg;
    logic [7:0] a_next, x_next, y_next, sp_next;
    logic c_next, z_next, n_next, v_next, i_next;
    logic [7:0] wb, m, sh, cmp_l, pl, st;
    logic [8:0] sum, diff, sa;
    logic       wr, cond, do_nz, shc;
    logic [7:0] nzv;
    logic [15:0] tgt, off;
    logic       out_valid_reg;
    logic       fire;

    assign fire  = q_valid && (!out_valid_reg || !stall_out);
    assign q_pop = fire;
    assign m     = q_word.operand;
    assign st    = {n_reg, v_reg, 1'b1, 1'b0, 1'b0, i_reg, z_reg, c_reg};
    assign sum   = {1'b0, a_reg} + {1'b0, m} + {8'd0, c_reg};
    assign diff  = {1'b0, a_reg} + {1'b0, ~m} + {8'd0, c_reg};
    assign off   = {{8{m[7]}}, m};
    assign pl    = (m & PlpMask) | 8'h20;

    always_comb
    begin
        unique case (q_word.op)
            OP_CPX:  cmp_l = x_reg;
            OP_CPY:  cmp_l = y_reg;
            default: cmp_l = a_reg;
        endcase
        // shifter source: accumulator forms or memory byte
        sh  = (q_word.op <= OP_RORA) ? a_reg : m;
        shc = 1'b0;
        unique case (2'(q_word.op - OP_ASLA))
            2'd0: begin shc = sh[7]; sh = {sh[6:0], 1'b0}; end
            2'd1: begin shc = sh[0]; sh = {1'b0, sh[7:1]}; end
            2'd2: begin shc = sh[7]; sh = {sh[6:0], c_reg}; end
            2'd3: begin shc = sh[0]; sh = {c_reg, sh[7:1]}; end
        endcase
    end

    always_comb
    begin
        a_next = a_reg; x_next = x_reg; y_next = y_reg; sp_next = sp_reg;
        c_next = c_reg; z_next = z_reg; n_next = n_reg; v_next = v_reg;
        i_next = i_reg;
        wb = 8'd0; wr = 1'b0; sa = 9'd0; cond = 1'b0;
        do_nz = 1'b0; nzv = 8'd0;
        unique case (q_word.op)
            OP_LDA: begin a_next = m; nzv = m; do_nz = 1'b1; end
            OP_LDX: begin x_next = m; nzv = m; do_nz = 1'b1; end
            OP_LDY: begin y_next = m; nzv = m; do_nz = 1'b1; end
            OP_STA: begin wb = a_reg; wr = 1'b1; end
            OP_STX: begin wb = x_reg; wr = 1'b1; end
            OP_STY: begin wb = y_reg; wr = 1'b1; end
            OP_ADC:
            begin
                a_next = sum[7:0]; c_next = sum[8];
                v_next = ~(a_reg[7] ^ m[7]) & (a_reg[7] ^ sum[7]);
                nzv = sum[7:0]; do_nz = 1'b1;
            end
            OP_SBC:
            begin
                a_next = diff[7:0]; c_next = diff[8];
                v_next = (a_reg[7] ^ m[7]) & (a_reg[7] ^ diff[7]);
                nzv = diff[7:0]; do_nz = 1'b1;
            end
            OP_AND: begin a_next = a_reg & m; nzv = a_next; do_nz = 1'b1; end
            OP_ORA: begin a_next = a_reg | m; nzv = a_next; do_nz = 1'b1; end
            OP_EOR: begin a_next = a_reg ^ m; nzv = a_next; do_nz = 1'b1; end
            OP_CMP, OP_CPX, OP_CPY:
            begin
                c_next = (cmp_l >= m); nzv = cmp_l - m; do_nz = 1'b1;
            end
            OP_BIT:
            begin
                z_next = ((a_reg & m) == 8'd0); n_next = m[7]; v_next = m[6];
            end
            OP_ASLA, OP_LSRA, OP_ROLA, OP_RORA:
            begin
                a_next = sh; c_next = shc; nzv = sh; do_nz = 1'b1;
            end
            OP_ASLM, OP_LSRM, OP_ROLM, OP_RORM:
            begin
                wb = sh; wr = 1'b1; c_next = shc; nzv = sh; do_nz = 1'b1;
            end
            OP_INC: begin wb = m + 8'd1; wr = 1'b1; nzv = wb; do_nz = 1'b1; end
            OP_DEC: begin wb = m - 8'd1; wr = 1'b1; nzv = wb; do_nz = 1'b1; end
            OP_INX: begin x_next = x_reg + 8'd1; nzv = x_next; do_nz = 1'b1; end
            OP_INY: begin y_next = y_reg + 8'd1; nzv = y_next; do_nz = 1'b1; end
            OP_DEX: begin x_next = x_reg - 8'd1; nzv = x_next; do_nz = 1'b1; end
            OP_DEY: begin y_next = y_reg - 8'd1; nzv = y_next; do_nz = 1'b1; end
            OP_TAX: begin x_next = a_reg; nzv = a_reg; do_nz = 1'b1; end
            OP_TAY: begin y_next = a_reg; nzv = a_reg; do_nz = 1'b1; end
            OP_TSX: begin x_next = sp_reg; nzv = sp_reg; do_nz = 1'b1; end
            OP_TXA: begin a_next = x_reg; nzv = x_reg; do_nz = 1'b1; end
            OP_TXS: sp_next = x_reg;
            OP_TYA: begin a_next = y_reg; nzv = y_reg; do_nz = 1'b1; end
            OP_CLC: c_next = 1'b0;
            OP_SEC: c_next = 1'b1;
            OP_CLI: i_next = 1'b0;
            OP_SEI: i_next = 1'b1;
            OP_CLV: v_next = 1'b0;
            OP_PHA, OP_PHP:
            begin
                sa = StackPage | {1'b0, sp_reg};
                wb = (q_word.op == OP_PHA) ? a_reg : (st | PhpMark);
                wr = 1'b1; sp_next = sp_reg - 8'd1;
            end
            OP_PLA:
            begin
                sp_next = sp_reg + 8'd1; sa = StackPage | {1'b0, sp_next};
                a_next = m; nzv = m; do_nz = 1'b1;
            end
            OP_PLP:
            begin
                sp_next = sp_reg + 8'd1; sa = StackPage | {1'b0, sp_next};
                n_next = pl[7]; v_next = pl[6]; i_next = pl[2];
                z_next = pl[1]; c_next = pl[0];
            end
            OP_BCC: cond = !c_reg;
            OP_BCS: cond = c_reg;
            OP_BEQ: cond = z_reg;
            OP_BNE: cond = !z_reg;
            OP_BPL: cond = !n_reg;
            OP_BMI: cond = n_reg;
            OP_BVC: cond = !v_reg;
            OP_BVS: cond = v_reg;
            default: ;
        endcase
        if (do_nz)
        begin
            z_next = (nzv == 8'd0); n_next = nzv[7];
        end
        cond = cond && (q_word.cls == CL_BRANCH);
        tgt  = cond ? (q_word.pc + off) : q_word.pc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= 8'd0; x_reg <= 8'd0; y_reg <= 8'd0; sp_reg <= SpReset;
            c_reg <= 1'b0; z_reg <= 1'b0; n_reg <= 1'b0; v_reg <= 1'b0;
            i_reg <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                a_reg <= a_next; x_reg <= x_next; y_reg <= y_next;
                sp_reg <= sp_next; c_reg <= c_next; z_reg <= z_next;
                n_reg <= n_next; v_reg <= v_next; i_reg <= i_next;
                out_valid_reg <= 1'b1;
            end
            else if (!stall_out)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_byte   <= wb;
            mem_write     <= wr;
            stack_address <= sa;
            acc_out       <= a_next;
            x_out         <= x_next;
            y_out         <= y_next;
            status_out    <= {n_next, v_next, 1'b1, 1'b0, 1'b0, i_next, z_next, c_next};
            sp_out        <= sp_next;
            branch_taken  <= cond;
            branch_target <= tgt;
            page_crossed  <= cond && ((q_word.pc & PageMask) != (tgt & PageMask));
        end
    end

    assign valid_out = out_valid_reg;
endmodule

/* src/cpu_8bit_execute_unit.sv */
// 8-bit CPU execute unit: A, X, Y, SP and flags with one ALU step per word.
// Path: an accepted word is first written into a queue entry, and the back end
// loads its result registers when it pops that word from the queue.
// Throughput: one word per cycle while stall_out is low; the back end's ALU/flag
// update sets the rate, and the 2-entry queue absorbs output stalls.
// Reset (rst_n low, async): queue and output empty, A/X/Y = 0, SP = 0xFD,
// flags clear except I = 1.
module cpu_8bit_execute_unit #(
    parameter int unsigned QUEUE_DEPTH = cpu8_pkg::QueueDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid_in,
    output logic        stall_in,
    input  logic [5:0]  op,
    input  logic [7:0]  operand,
    input  logic [15:0] pc_in,
    output logic        valid_out,
    input  logic        stall_out,
    output logic [7:0]  result_byte,
    output logic        mem_write,
    output logic [8:0]  stack_address,
    output logic [7:0]  acc_out,
    output logic [7:0]  x_out,
    output logic [7:0]  y_out,
    output logic [7:0]  status_out,
    output logic [7:0]  sp_out,
    output logic        branch_taken,
    output logic [15:0] branch_target,
    output logic        page_crossed
);
    import cpu8_pkg::*;

    // front end: classify word and queue it
    logic       q_valid, q_pop;
    cpu8_word_t q_word;

    cpu8_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .valid_in(valid_in), .stall_in(stall_in),
        .op(op), .operand(operand), .pc_in(pc_in),
        .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word)
    );

    // back end: register file, ALU, branch unit, output register
    cpu8_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_pop(q_pop), .q_word(q_word),
        .valid_out(valid_out), .stall_out(stall_out),
        .result_byte(result_byte), .mem_write(mem_write),
        .stack_address(stack_address), .acc_out(acc_out),
        .x_out(x_out), .y_out(y_out), .status_out(status_out),
        .sp_out(sp_out), .branch_taken(branch_taken),
        .branch_target(branch_target), .page_crossed(page_crossed)
    );

    // status bit 5 always reads one, B and D zero
    a_status_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out |-> (status_out[5] && !status_out[4] && !status_out[3]))
        else $error("status fixed bits wrong");

    // page cross only on taken branch
    a_cross_taken: assert property (@(posedge clk) disable iff (!rst_n)
        valid_out && page_crossed |-> branch_taken)
        else $error("page cross without taken branch");

    // queue pops only when it has a word
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // a queued word always produces an output next cycle
    a_pop_out: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> valid_out)
        else $error("popped word lost");
endmodule
